@@ hw/rtl/pfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// pfpr_pkg
// Shared constants and types for the PWM frequency to prescale/reload block.
// ----------------------------------------------------------------------------
package pfpr_pkg;

  localparam int unsigned ClkW      = 32;          // clock and request width
  localparam int unsigned PscW      = 17;          // prescaler divisor, 1..65536
  localparam int unsigned OutW      = 16;          // register field width
  localparam logic [ClkW-1:0] ClockReset = 32'd72000000;
  localparam logic [PscW-1:0] PscMax     = 17'd65536;

  typedef struct packed {
    logic            stop_counter;
    logic [OutW-1:0] prescale;
    logic [OutW-1:0] reload;
    logic [OutW-1:0] compare;
  } res_word_t;

endpackage

@@ hw/rtl/pfpr_if.sv @@
// ----------------------------------------------------------------------------
// pfpr channel interfaces
// Valid/ready channels for requests, clock configuration and results.
// ----------------------------------------------------------------------------
interface pfpr_freq_if import pfpr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ClkW-1:0] freq_hz;
  modport source (output valid, output freq_hz, input ready);
  modport sink   (input valid, input freq_hz, output ready);
endinterface

interface pfpr_cfg_if import pfpr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ClkW-1:0] clock_hz;
  modport source (output valid, output clock_hz, input ready);
  modport sink   (input valid, input clock_hz, output ready);
endinterface

interface pfpr_res_if import pfpr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            stop_counter;
  logic [OutW-1:0] prescale;
  logic [OutW-1:0] reload;
  logic [OutW-1:0] compare;
  modport source (output valid, output stop_counter, output prescale,
                  output reload, output compare, input ready);
  modport sink   (input valid, input stop_counter, input prescale,
                  input reload, input compare, output ready);
endinterface

@@ hw/rtl/pfpr_div.sv @@
// ----------------------------------------------------------------------------
// pfpr_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module pfpr_div #(
  parameter int NW = 32,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          pv;
    logic [DW-1:0] prem;
    logic [NW-1:0] pquo;
    logic [NW-1:0] pnum;
    logic [DW-1:0] pden;
    logic [SW-1:0] pside;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign pv    = valid_i;
      assign prem  = '0;
      assign pquo  = '0;
      assign pnum  = num_i;
      assign pden  = den_i;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_q[k-1];
      assign prem  = rem_q[k-1];
      assign pquo  = quo_q[k-1];
      assign pnum  = num_q[k-1];
      assign pden  = den_q[k-1];
      assign pside = side_q[k-1];
    end

    assign trial = {prem, pnum[NW-1]};
    assign diff  = trial - {1'b0, pden};
    assign ge    = trial >= {1'b0, pden};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_q[k]  <= {pquo[NW-2:0], ge};
        num_q[k]  <= {pnum[NW-2:0], 1'b0};
        den_q[k]  <= pden;
        side_q[k] <= pside;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

@@ hw/rtl/pwm_freq_to_prescale_reload.sv @@
// ----------------------------------------------------------------------------
// pwm_freq_to_prescale_reload
// Turns a PWM frequency request into prescaler, reload and compare values.
// ----------------------------------------------------------------------------
// Usage:
//   freq_i  : request word, freq_hz in Hz; zero asks to stop the counter.
//   cfg_i   : timer input clock in Hz (clock_hz), always ready; write it only
//             while no request is in flight. Reset value is 72 MHz.
//   res_o   : result word: stop_counter, prescale (P-1), odd reload and
//             compare = (reload+1)/2.
// Throughput: one word per cycle while the output register is not stalled.
//   The pipeline has 104 register stages: input register, 33 + 34 + 32
//   divider stages, three intermediate registers and the output register.
//   The three bit-serial divider pipelines (one quotient bit per stage)
//   are clock/freq, divisor/prescaler, and clock/(P*(reload+1)), the last
//   run twice in parallel for the two odd reload candidates.
// Stall: the whole pipeline holds while a result sits unaccepted in the
//   output register; freq_i.ready drops at the same time, nothing is lost.
// Reset: rst_ni clears all valid bits and restores clock_hz.
// ----------------------------------------------------------------------------
module pwm_freq_to_prescale_reload import pfpr_pkg::*; #(
  parameter int RELOAD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfpr_freq_if.sink   freq_i,
  pfpr_cfg_if.sink    cfg_i,
  pfpr_res_if.source  res_o
);

  localparam int RB = RELOAD_BITS;
  localparam int PW = PscW + RB + 1;                 // P * (reload+1)
  localparam logic [32:0] SpanM1 = 33'((64'd1 << RB) - 64'd1);
  localparam logic [33:0] Span34 = 34'(64'd1 << RB);

  // Clock register and global advance.
  logic [ClkW-1:0] clk_hz_q;
  logic            out_v_q;
  res_word_t       out_q;
  logic            en;

  assign en           = !out_v_q || res_o.ready;
  assign freq_i.ready = en;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClockReset;
    end else if (cfg_i.valid) begin
      clk_hz_q <= cfg_i.clock_hz;
    end
  end

  // Input register.
  logic            s0_v_q;
  logic [ClkW-1:0] s0_f_q, s0_clk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= freq_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_f_q   <= freq_i.freq_hz;
      s0_clk_q <= clk_hz_q;
    end
  end

  // Divider 1: D = round(clock / freq).
  localparam int S1W = 1 + 2 * ClkW;
  logic            s0_stop;
  logic [32:0]     d1_num;
  logic [31:0]     d1_den;
  logic            d1_v;
  logic [32:0]     d1_q;
  logic [S1W-1:0]  d1_side;

  assign s0_stop = (s0_f_q == '0);
  assign d1_num  = {1'b0, s0_clk_q} + {2'b0, s0_f_q[31:1]};
  assign d1_den  = s0_stop ? 32'd1 : s0_f_q;

  pfpr_div #(.NW(33), .DW(32), .SW(S1W)) u_div_d (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s0_v_q), .num_i(d1_num), .den_i(d1_den),
    .side_i({s0_stop, s0_clk_q, s0_f_q}),
    .valid_o(d1_v), .quo_o(d1_q), .side_o(d1_side)
  );

  // Stage A: clamp D, prescaler P = ceil(D / 2^RB) in 1..65536.
  logic [31:0] a_d;
  logic [32:0] a_psum;
  logic [32:0] a_praw;
  logic [PscW-1:0] a_p;

  assign a_d    = (d1_q[31:0] < 32'd2) ? 32'd2 : d1_q[31:0];
  assign a_psum = {1'b0, a_d} + SpanM1;
  assign a_praw = a_psum >> RB;
  assign a_p    = (a_praw > {16'b0, PscMax}) ? PscMax : a_praw[PscW-1:0];

  logic            sa_v_q;
  logic [S1W-1:0]  sa_side_q;
  logic [31:0]     sa_d_q;
  logic [PscW-1:0] sa_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
    end else if (en) begin
      sa_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_side_q <= d1_side;
      sa_d_q    <= a_d;
      sa_p_q    <= a_p;
    end
  end

  // Divider 2: C = round(D / P).
  localparam int S2W = S1W + PscW;
  logic [33:0]    d2_num;
  logic           d2_v;
  logic [33:0]    d2_q;
  logic [S2W-1:0] d2_side;

  assign d2_num = {2'b0, sa_d_q} + {18'b0, sa_p_q[PscW-1:1]};

  pfpr_div #(.NW(34), .DW(PscW), .SW(S2W)) u_div_c (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(sa_v_q), .num_i(d2_num), .den_i(sa_p_q),
    .side_i({sa_side_q, sa_p_q}),
    .valid_o(d2_v), .quo_o(d2_q), .side_o(d2_side)
  );

  // Stage B: clamp C to 2..2^RB, reload = C-1, odd neighbors.
  logic [33:0]   b_c;
  logic [RB-1:0] b_arr, b_lo, b_hi;

  always_comb begin
    b_c = d2_q;
    if (d2_q < 34'd2) begin
      b_c = 34'd2;
    end else if (d2_q > Span34) begin
      b_c = Span34;
    end
  end

  assign b_arr = RB'(b_c - 34'd1);
  // Even reload is never the top value, so its upper odd neighbor fits.
  assign b_lo  = b_arr[0] ? b_arr : b_arr - RB'(1);
  assign b_hi  = b_arr | RB'(1);

  logic           sb_v_q;
  logic [S2W-1:0] sb_side_q;
  logic [RB-1:0]  sb_lo_q, sb_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= 1'b0;
    end else if (en) begin
      sb_v_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_side_q <= d2_side;
      sb_lo_q   <= b_lo;
      sb_hi_q   <= b_hi;
    end
  end

  // Stage C: periods P*(lo+1) and P*(hi+1).
  logic [PscW-1:0] sb_p;
  logic [PW-1:0]   c_mlo, c_mhi;

  assign sb_p  = sb_side_q[PscW-1:0];
  assign c_mlo = PW'(sb_p) * PW'({1'b0, sb_lo_q} + (RB+1)'(1));
  assign c_mhi = PW'(sb_p) * PW'({1'b0, sb_hi_q} + (RB+1)'(1));

  localparam int S3W = 1 + ClkW + PscW + 2 * RB;
  logic            sc_v_q;
  logic [ClkW-1:0] sc_clk_q;
  logic [S3W-1:0]  sc_side_q;
  logic [PW-1:0]   sc_mlo_q, sc_mhi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else if (en) begin
      sc_v_q <= sb_v_q;
    end
  end

  // side layout into the candidate dividers: stop, f, p, lo, hi
  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_clk_q  <= sb_side_q[PscW+ClkW +: ClkW];
      sc_side_q <= {sb_side_q[S2W-1], sb_side_q[PscW +: ClkW], sb_p, sb_lo_q, sb_hi_q};
      sc_mlo_q  <= c_mlo;
      sc_mhi_q  <= c_mhi;
    end
  end

  // Dividers 3 and 4: actual frequencies for both candidates, in lockstep.
  logic            d3_v, d4_v;
  logic [ClkW-1:0] d3_q, d4_q;
  logic [S3W-1:0]  d3_side;
  logic            d4_side;

  pfpr_div #(.NW(ClkW), .DW(PW), .SW(S3W)) u_div_lo (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(sc_v_q), .num_i(sc_clk_q), .den_i(sc_mlo_q), .side_i(sc_side_q),
    .valid_o(d3_v), .quo_o(d3_q), .side_o(d3_side)
  );

  pfpr_div #(.NW(ClkW), .DW(PW), .SW(1)) u_div_hi (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(sc_v_q), .num_i(sc_clk_q), .den_i(sc_mhi_q), .side_i(1'b0),
    .valid_o(d4_v), .quo_o(d4_q), .side_o(d4_side)
  );

  // Stage D: pick the nearer candidate (ties go low), form the result word.
  logic            e_stop;
  logic [ClkW-1:0] e_f;
  logic [PscW-1:0] e_p;
  logic [RB-1:0]   e_lo, e_hi, e_pick;
  logic [ClkW-1:0] e_dlo, e_dhi;
  logic [32:0]     e_pick_w, e_cmp_w;
  logic [PscW-1:0] e_pm1;
  res_word_t       e_res;

  assign e_stop = d3_side[S3W-1];
  assign e_f    = d3_side[PscW+2*RB +: ClkW];
  assign e_p    = d3_side[2*RB +: PscW];
  assign e_lo   = d3_side[RB +: RB];
  assign e_hi   = d3_side[0 +: RB];
  assign e_dlo  = (d3_q > e_f) ? d3_q - e_f : e_f - d3_q;
  assign e_dhi  = (d4_q > e_f) ? d4_q - e_f : e_f - d4_q;
  assign e_pick = (e_dlo <= e_dhi) ? e_lo : e_hi;
  assign e_pick_w = 33'(e_pick);
  assign e_cmp_w  = (e_pick_w + 33'd1) >> 1;
  assign e_pm1    = e_p - PscW'(1);

  always_comb begin
    if (e_stop) begin
      e_res = '{stop_counter: 1'b1, prescale: '0, reload: '0, compare: '0};
    end else begin
      e_res = '{stop_counter: 1'b0, prescale: e_pm1[OutW-1:0],
                reload: e_pick_w[OutW-1:0], compare: e_cmp_w[OutW-1:0]};
    end
  end

  // Output register. d4 valid and sideband mirror d3.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d3_v & (d4_v | d4_side | 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= e_res;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.stop_counter = out_q.stop_counter;
  assign res_o.prescale     = out_q.prescale;
  assign res_o.reload       = out_q.reload;
  assign res_o.compare      = out_q.compare;

endmodule
